FILE: src/per_source_latency_statistics_assert.svh
// -----------------------------------------------------------------------------
// per_source_latency_statistics_assert.svh
// Assertion macros shared by the statistics block.
// -----------------------------------------------------------------------------
`ifndef PER_SOURCE_LATENCY_STATISTICS_ASSERT_SVH
`define PER_SOURCE_LATENCY_STATISTICS_ASSERT_SVH

`ifndef SYNTH
`define PSLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PSLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PSLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/psls_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psls_pkg
// Types and constants of the per-source latency statistics block.
// -----------------------------------------------------------------------------
package psls_pkg;

	localparam int MAX_SOURCES = 16;
	localparam int SIDX_W      = $clog2(MAX_SOURCES);
	localparam int OP_W        = 2;
	localparam int SRC_W       = 4;
	localparam int CNT_W       = 32;
	localparam int SUM_W       = 48;
	localparam int CFG_W       = 5;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int DIV_CNT_W   = $clog2(SUM_W);

	localparam logic [CFG_W-1:0] NUM_SOURCES_RST = CFG_W'(16);
	localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};

	localparam logic [OP_W-1:0] OP_MADE  = 2'd0;
	localparam logic [OP_W-1:0] OP_EATEN = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SRC_W-1:0] idx;
		logic [CNT_W-1:0] delay;
		logic             err;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] made;
		logic [CNT_W-1:0] eaten;
		logic [CNT_W-1:0] mn;
		logic [CNT_W-1:0] mx;
		logic [SUM_W-1:0] sum;
	} rec_t;

	typedef struct packed {
		logic [CNT_W-1:0] made;
		logic [CNT_W-1:0] eaten;
		logic [CNT_W-1:0] mn;
		logic [CNT_W-1:0] mx;
		logic [CNT_W-1:0] mean;
		logic             mismatch;
		logic             err;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

FILE: src/psls_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psls_if
// Channel interfaces: input words, result words and configuration writes.
// -----------------------------------------------------------------------------
interface psls_item_if import psls_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [SRC_W-1:0] source_index;
	logic [CNT_W-1:0] delay;

	modport source (output valid, operation, source_index, delay, input ready);
	modport sink (input valid, operation, source_index, delay, output ready);
endinterface

interface psls_result_if import psls_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] made_count;
	logic [CNT_W-1:0] eaten_count;
	logic [CNT_W-1:0] low_delay;
	logic [CNT_W-1:0] high_delay;
	logic [CNT_W-1:0] mean_delay;
	logic             count_mismatch;
	logic             index_error;

	modport source (output valid, made_count, eaten_count, low_delay, high_delay,
		mean_delay, count_mismatch, index_error, input ready);
	modport sink (input valid, made_count, eaten_count, low_delay, high_delay,
		mean_delay, count_mismatch, index_error, output ready);
endinterface

interface psls_cfg_if import psls_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: src/psls_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psls_front
// Holds the source count register, takes input words and flags bad indices.
// -----------------------------------------------------------------------------
module psls_front import psls_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	psls_cfg_if.sink     cfg,
	psls_item_if.sink    item,
	input  logic         q_full,
	output logic         q_push,
	output cmd_t         q_data
);

	logic [CFG_W-1:0] num_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_SOURCES_RST;
		end else if (cfg.valid) begin
			num_q <= cfg.data;
		end
	end

	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full;

	always_comb begin
		q_data       = '0;
		q_data.op    = item.operation;
		q_data.idx   = item.source_index;
		q_data.delay = item.delay;
		q_data.err   = ({1'b0, item.source_index} >= num_q)
			|| (32'(item.source_index) >= MAX_SOURCES);
	end

endmodule

FILE: src/psls_fifo.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psls_fifo
// Short command queue between the front and the record engine.
// -----------------------------------------------------------------------------
module psls_fifo import psls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: src/psls_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psls_div
// Radix-2 restoring divider, delay sum over eaten count, one bit a cycle.
// -----------------------------------------------------------------------------
module psls_div import psls_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [CNT_W-1:0] quotient
);

	logic [SUM_W-1:0]     dq_q;
	logic [CNT_W-1:0]     dvr_q;
	logic [CNT_W:0]       rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W:0]       rem_sh;
	logic                 ge;
	logic                 last;

	assign rem_sh = {rem_q[CNT_W-1:0], dq_q[SUM_W-1]};
	assign ge     = (rem_sh >= {1'b0, dvr_q});
	assign last   = (cnt_q == DIV_CNT_W'(SUM_W-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dvr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dvr_q} : rem_sh;
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = (|dq_q[SUM_W-1:CNT_W]) ? CNT_MAX : dq_q[CNT_W-1:0];

endmodule

FILE: src/psls_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psls_back
// Record engine: read-modify-write of one source record, mean, result word.
// -----------------------------------------------------------------------------
`include "per_source_latency_statistics_assert.svh"

module psls_back import psls_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  cmd_t           q_data,
	output logic           q_pop,
	psls_result_if.source  result
);

	typedef struct packed {
		logic pop;
		logic wr;
		logic div_start;
		logic mean_load;
	} bk_ctl_t;

	bk_state_t         state_q;
	bk_state_t         state_d;
	bk_ctl_t           ctl;
	rec_t              rec_q [MAX_SOURCES];
	logic [MAX_SOURCES-1:0] vld_q;
	res_t              res_q;
	rec_t              cur;
	rec_t              upd;
	logic [SIDX_W-1:0] sidx;
	logic [SUM_W:0]    sum_w;
	logic              div_busy;
	logic              div_done;
	logic [CNT_W-1:0]  div_q;

	assign sidx = q_data.idx[SIDX_W-1:0];
	assign cur  = vld_q[sidx] ? rec_q[sidx] : '0;

	always_comb begin
		upd   = cur;
		sum_w = {1'b0, cur.sum} + (SUM_W+1)'(q_data.delay);
		case (q_data.op)
			OP_MADE: begin
				if (cur.made != CNT_MAX) upd.made = cur.made + 1'b1;
			end
			OP_EATEN: begin
				if (cur.eaten != CNT_MAX) upd.eaten = cur.eaten + 1'b1;
				if (cur.eaten == '0 || q_data.delay < cur.mn) upd.mn = q_data.delay;
				if (q_data.delay > cur.mx) upd.mx = q_data.delay;
				upd.sum = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
			end
			OP_QUERY: begin
				upd = cur;
			end
			default: begin
				upd = cur;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (q_data.err || upd.eaten == '0) state_d = BK_OUT;
					else state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_done) state_d = BK_OUT;
			end
			BK_OUT: begin
				if (result.ready) state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.pop       = (state_q == BK_IDLE) && !q_empty;
		ctl.wr        = ctl.pop && !q_data.err;
		ctl.div_start = ctl.wr && (upd.eaten != '0);
		ctl.mean_load = (state_q == BK_DIV) && div_done;
	end

	assign q_pop = ctl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.wr) vld_q[sidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			rec_q[sidx] <= upd;
		end
		if (ctl.pop) begin
			if (q_data.err) begin
				res_q <= '{made: '0, eaten: '0, mn: '0, mx: '0, mean: '0,
					mismatch: 1'b0, err: 1'b1};
			end else begin
				res_q <= '{made: upd.made, eaten: upd.eaten, mn: upd.mn, mx: upd.mx,
					mean: '0, mismatch: (upd.made != upd.eaten), err: 1'b0};
			end
		end else if (ctl.mean_load) begin
			res_q.mean <= div_q;
		end
	end

	psls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (upd.sum),
		.divisor  (upd.eaten),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign result.valid          = (state_q == BK_OUT);
	assign result.made_count     = res_q.made;
	assign result.eaten_count    = res_q.eaten;
	assign result.low_delay      = res_q.mn;
	assign result.high_delay     = res_q.mx;
	assign result.mean_delay     = res_q.mean;
	assign result.count_mismatch = res_q.mismatch;
	assign result.index_error    = res_q.err;

	`PSLS_ASSERT_IMP(a_div_in_div, clk, arst_n, div_busy || div_done, state_q == BK_DIV)
	`PSLS_ASSERT_NXT(a_start_div, clk, arst_n, ctl.div_start, div_busy && state_q == BK_DIV)
	`PSLS_ASSERT_IMP(a_err_zero, clk, arst_n, result.valid && result.index_error, result.made_count == '0 && result.eaten_count == '0 && !result.count_mismatch)
	`PSLS_ASSERT_IMP(a_none_eaten, clk, arst_n, result.valid && result.eaten_count == '0, result.mean_delay == '0 && result.low_delay == '0 && result.high_delay == '0)

endmodule

FILE: src/per_source_latency_statistics.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// per_source_latency_statistics
// Per-source made/eaten counts and min, max and mean consumption delay.
// -----------------------------------------------------------------------------
// Channels: item (operation, source_index, delay) in, result (record after the
// update, count_mismatch, index_error) out, one result word per item word;
// cfg writes num_sources and is always ready.
// A two-entry queue sits behind the item port, so item words are taken while
// a result waits; the record engine works one word at a time.
// When the engine picks a word whose index is in error or whose source has
// nothing eaten, result valid follows in the next cycle; otherwise it waits
// for the one-bit-per-cycle divider over the 48-bit delay sum. The engine
// picks its next word only after the receiver has taken the result.
// Reset clears every record (per-entry valid bits) and sets num_sources to 16.
// A stalled receiver holds the result steady; item ready drops once the queue
// has filled.
// -----------------------------------------------------------------------------
module per_source_latency_statistics import psls_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	psls_cfg_if.sink      cfg,
	psls_item_if.sink     item,
	psls_result_if.source result
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_in;
	cmd_t q_out;

	psls_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	psls_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	psls_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule
